@@ rtl/core/lppd_pkg.sv @@
// Shared types and constants for the length-prefixed packet deframer.
// Holds the status codes, the register indexes and the per-byte result record.
// No dependencies.
package lppd_pkg;

    // Header size in bytes; the declared length includes it
    localparam logic [15:0] HEADER_BYTES = 16'd4;

    // Header byte offsets
    localparam logic [15:0] POS_HDR    = 16'd0;
    localparam logic [15:0] POS_ID     = 16'd1;
    localparam logic [15:0] POS_LEN_LO = 16'd2;
    localparam logic [15:0] POS_LEN_HI = 16'd3;

    // Configuration register indexes
    localparam logic CFG_HEADER_MAIN = 1'b0;
    localparam logic CFG_HEADER_ALT  = 1'b1;

    // Configuration reset values
    localparam logic [7:0] HEADER_MAIN_RESET = 8'd247;
    localparam logic [7:0] HEADER_ALT_RESET  = 8'd248;

    // Status codes reported with each byte
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_HDR = 2'd1,
        STATUS_BAD_LEN = 2'd2,
        STATUS_HALTED  = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] byte_pos;
        logic        first_of_packet;
        logic        last_of_packet;
        logic        header_kind;
        logic [7:0]  packet_id;
        status_t     status;
        logic [31:0] main_count;
    } result_t;

endpackage

@@ rtl/core/lppd_parser.sv @@
// Packet parser: framing state, configuration registers and per-byte result logic.
// Depends on lppd_pkg.
module lppd_parser
    import lppd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output result_t    result
);

    logic [7:0]  header_main_reg;
    logic [7:0]  header_alt_reg;
    logic        halted_reg,        halted_next;
    logic [15:0] position_reg,      position_next;
    logic [15:0] packet_length_reg, packet_length_next;
    logic [7:0]  first_byte_reg,    first_byte_next;
    logic [7:0]  id_byte_reg,       id_byte_next;
    logic [7:0]  length_low_reg,    length_low_next;
    logic [31:0] packets_seen_reg,  packets_seen_next;

    logic        is_main;
    logic        is_alt;
    logic [15:0] len;
    logic [16:0] pos_inc;

    // Header fields with the current byte forwarded in
    assign first_byte_next = (position_reg == POS_HDR)    ? data_byte : first_byte_reg;
    assign id_byte_next    = (position_reg == POS_ID)     ? data_byte : id_byte_reg;
    assign length_low_next = (position_reg == POS_LEN_LO) ? data_byte : length_low_reg;
    assign is_main = (first_byte_next == header_main_reg);
    assign is_alt  = (first_byte_next == header_alt_reg);
    assign len     = {data_byte, length_low_reg};
    assign pos_inc = {1'b0, position_reg} + 17'd1;

    // Framing decision and result for the byte at the input
    always_comb
    begin
        halted_next        = halted_reg;
        position_next      = position_reg;
        packet_length_next = packet_length_reg;
        packets_seen_next  = packets_seen_reg;

        result.out_byte        = data_byte;
        result.byte_pos        = position_reg;
        result.first_of_packet = 1'b0;
        result.last_of_packet  = 1'b0;
        result.header_kind     = 1'b0;
        result.packet_id       = 8'd0;
        result.status          = STATUS_OK;

        if (halted_reg)
        begin
            result.byte_pos = 16'd0;
            result.status   = STATUS_HALTED;
        end
        else
        begin
            result.first_of_packet = (position_reg == POS_HDR);
            result.header_kind     = !is_main;
            result.packet_id       = (position_reg == POS_HDR) ? 8'd0 : id_byte_next;

            if (position_reg == POS_LEN_HI)
            begin
                // Header complete: check constant, then length
                if (!is_main && !is_alt)
                begin
                    result.status = STATUS_BAD_HDR;
                    halted_next   = 1'b1;
                    position_next = 16'd0;
                end
                else if (len < HEADER_BYTES)
                begin
                    result.status = STATUS_BAD_LEN;
                    halted_next   = 1'b1;
                    position_next = 16'd0;
                end
                else
                begin
                    packet_length_next = len;
                    if (len == HEADER_BYTES)
                    begin
                        result.last_of_packet = 1'b1;
                        position_next         = 16'd0;
                        if (is_main)
                        begin
                            packets_seen_next = packets_seen_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        position_next = HEADER_BYTES;
                    end
                end
            end
            else if (position_reg > POS_LEN_HI && pos_inc >= {1'b0, packet_length_reg})
            begin
                // Last payload byte
                result.last_of_packet = 1'b1;
                position_next         = 16'd0;
                if (is_main)
                begin
                    packets_seen_next = packets_seen_reg + 32'd1;
                end
            end
            else
            begin
                position_next = pos_inc[15:0];
            end
        end

        result.main_count = packets_seen_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_main_reg <= HEADER_MAIN_RESET;
            header_alt_reg  <= HEADER_ALT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_HEADER_MAIN: header_main_reg <= cfg_data;
                CFG_HEADER_ALT:  header_alt_reg  <= cfg_data;
                default:         header_main_reg <= header_main_reg;
            endcase
        end
    end

    // Framing state, advanced once per accepted item while not halted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg        <= 1'b0;
            position_reg      <= 16'd0;
            packet_length_reg <= 16'd0;
            first_byte_reg    <= 8'd0;
            id_byte_reg       <= 8'd0;
            length_low_reg    <= 8'd0;
            packets_seen_reg  <= 32'd0;
        end
        else if (accept && !halted_reg)
        begin
            halted_reg        <= halted_next;
            position_reg      <= position_next;
            packet_length_reg <= packet_length_next;
            first_byte_reg    <= first_byte_next;
            id_byte_reg       <= id_byte_next;
            length_low_reg    <= length_low_next;
            packets_seen_reg  <= packets_seen_next;
        end
    end

`ifndef SYNTHESIS
    // Error state is sticky
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // Once halted, framing position is parked at zero
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |-> position_reg == 16'd0)
        else $error("position nonzero while halted");

    // Packet counter only moves by one, and only on an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        packets_seen_reg != $past(packets_seen_reg) |->
            packets_seen_reg == $past(packets_seen_reg) + 32'd1 && $past(accept))
        else $error("packet counter jumped");

    // A completed packet always restarts framing at offset zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !halted_reg && result.last_of_packet |=> position_reg == 16'd0)
        else $error("position not reset after last byte");
`endif

endmodule

@@ rtl/core/lppd_out_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
// Depends on lppd_pkg.
module lppd_out_reg
    import lppd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    output logic    load_ready,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t result_out
);

    logic    out_valid_reg;
    result_t result_reg;

    // Free when empty or being drained this cycle
    assign load_ready = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            out_valid_reg <= load;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ rtl/core/length_prefixed_packet_deframer_unit.sv @@
// Length-prefixed packet deframer, top level. Uses lppd_pkg, lppd_parser, lppd_out_reg.
// The result item of a byte is registered and valid the cycle after it is accepted.
// Throughput: one byte per cycle, set by the single result register; input ready
//   drops only while a result is held by a stalled consumer.
// Reset: asynchronous, active low; clears framing state, packet count and output valid,
//   and loads header constants 247 (main) and 248 (alternate).
module length_prefixed_packet_deframer_unit
    import lppd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [15:0] byte_pos,
    output logic        first_of_packet,
    output logic        last_of_packet,
    output logic        header_kind,
    output logic [7:0]  packet_id,
    output logic [1:0]  status,
    output logic [31:0] main_count
);

    result_t parsed;
    result_t held;
    logic    accept;

    assign accept = in_valid && in_ready;

    lppd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .result       (parsed)
    );

    lppd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_valid),
        .result_in  (parsed),
        .load_ready (in_ready),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_out (held)
    );

    // Unpack the held item onto the output fields
    assign out_byte        = held.out_byte;
    assign byte_pos        = held.byte_pos;
    assign first_of_packet = held.first_of_packet;
    assign last_of_packet  = held.last_of_packet;
    assign header_kind     = held.header_kind;
    assign packet_id       = held.packet_id;
    assign status          = held.status;
    assign main_count      = held.main_count;

endmodule
